@@ sv/mf3_pkg.sv @@
// mf3_pkg: shared types, constants and compare helpers for the 3x3 median filter
// no dependencies; imported by the filter modules
`timescale 1ns / 1ps

package mf3_pkg;

	localparam int PADDR_W     = 3;
	localparam int OFIFO_DEPTH = 8;

	typedef logic [7:0] pix_t;

	typedef enum logic [0:0] {
		CMD_PIXEL = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_t;

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	// one window column, sorted
	typedef struct packed {
		pix_t hi;
		pix_t md;
		pix_t lo;
	} col_t;

	// control carried from the accept stage into the window stage
	typedef struct packed {
		logic shift;
		logic emit;
		logic interior;
		logic last;
		logic drain;
		logic j0;
	} stage_t;

	typedef struct packed {
		pix_t pixel_out;
		logic frame_end;
	} out_word_t;

	function automatic pix_t pmin(pix_t a, pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t pmax(pix_t a, pix_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
		return pmax(pmin(a, b), pmin(pmax(a, b), c));
	endfunction

	function automatic col_t sort3(pix_t a, pix_t b, pix_t c);
		pix_t lo1;
		pix_t hi1;
		pix_t t;
		col_t r;
		lo1  = pmin(a, b);
		hi1  = pmax(a, b);
		t    = pmin(hi1, c);
		r.hi = pmax(hi1, c);
		r.lo = pmin(lo1, t);
		r.md = pmax(lo1, t);
		return r;
	endfunction

endpackage

@@ sv/mf3_in_if.sv @@
// mf3_in_if: input channel of the median filter, valid/ready with cmd and pixel
// no dependencies
`timescale 1ns / 1ps

interface mf3_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] pixel_in;

	modport source (output valid, output cmd, output pixel_in, input ready);
	modport sink (input valid, input cmd, input pixel_in, output ready);
endinterface

@@ sv/mf3_out_if.sv @@
// mf3_out_if: result channel of the median filter, valid/ready with pixel and frame end
// no dependencies
`timescale 1ns / 1ps

interface mf3_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_out;
	logic       frame_end;

	modport source (output valid, output pixel_out, output frame_end, input ready);
	modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

@@ sv/mf3_ram.sv @@
// mf3_ram: generic simple dual port RAM, one write and one registered read port
// read-first when both ports hit the same address; no dependencies
`timescale 1ns / 1ps

module mf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/mf3_cfg.sv @@
// mf3_cfg: APB register file for frame width and height, with clamped copies
// depends on mf3_pkg
`timescale 1ns / 1ps

module mf3_cfg import mf3_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [PADDR_W-1:0]            paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output logic [$clog2(MAX_WIDTH)-1:0]  wm1,
	output logic [$clog2(MAX_HEIGHT)-1:0] hm1,
	output logic                          clr
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [11:0] width_q;
	logic [11:0] height_q;
	logic        wr;
	reg_idx_t    idx;

	// clamp to 3..mx and return the dimension minus one
	function automatic int unsigned dim_m1(logic [11:0] v, int unsigned mx);
		int unsigned d;
		d = 32'(v);
		if (d < 3) begin
			d = 3;
		end else if (d > mx) begin
			d = mx;
		end
		return d - 1;
	endfunction

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1]);
	assign wr     = psel & penable & pwrite & pready;
	assign clr    = wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd640;
			height_q <= 12'd480;
			wm1      <= CW'(dim_m1(12'd640, MAX_WIDTH));
			hm1      <= RW'(dim_m1(12'd480, MAX_HEIGHT));
		end else if (wr) begin
			case (idx)
				REG_WIDTH: begin
					width_q <= pwdata[11:0];
					wm1     <= CW'(dim_m1(pwdata[11:0], MAX_WIDTH));
				end
				REG_HEIGHT: begin
					height_q <= pwdata[11:0];
					hm1      <= RW'(dim_m1(pwdata[11:0], MAX_HEIGHT));
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WIDTH:  prdata = {20'd0, width_q};
			REG_HEIGHT: prdata = {20'd0, height_q};
			default:    prdata = '0;
		endcase
	end

endmodule

@@ sv/mf3_median.sv @@
// mf3_median: 3x3 window of sorted columns and the two-stage median of nine
// depends on mf3_pkg; fed by the row store read data
`timescale 1ns / 1ps

module mf3_median import mf3_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      clr,
	input  stage_t    s1,
	input  pix_t      pix_s1,
	input  pix_t      rd_upper,
	input  pix_t      rd_lower,
	output logic      push,
	output out_word_t push_word,
	output logic [1:0] pend
);

	col_t   col_q [3];
	pix_t   rawmid_q;
	logic   emit_s2;
	logic   int_s2;
	logic   last_s2;
	pix_t   val_s2;
	logic   emit_s3;
	logic   int_s3;
	logic   last_s3;
	pix_t   val_s3;
	pix_t   lo_s3;
	pix_t   mi_s3;
	pix_t   hi_s3;

	// window: col 2 is the newest column, rawmid_q its unsorted middle pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q[0] <= '0;
			col_q[1] <= '0;
			col_q[2] <= '0;
			rawmid_q <= '0;
		end else if (clr) begin
			col_q[0] <= '0;
			col_q[1] <= '0;
			col_q[2] <= '0;
			rawmid_q <= '0;
		end else if (s1.shift) begin
			col_q[0] <= col_q[1];
			col_q[1] <= col_q[2];
			col_q[2] <= sort3(rd_upper, rd_lower, pix_s1);
			rawmid_q <= rd_lower;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
			emit_s3 <= 1'b0;
		end else begin
			emit_s2 <= s1.emit;
			emit_s3 <= emit_s2;
		end
	end

	// the old newest middle becomes the center; drain words on the last row read the lower row
	always_ff @(posedge clk) begin
		int_s2  <= s1.interior;
		last_s2 <= s1.last;
		val_s2  <= (s1.drain && !s1.j0) ? rd_lower : rawmid_q;
		int_s3  <= int_s2;
		last_s3 <= last_s2;
		val_s3  <= val_s2;
		lo_s3   <= pmax(pmax(col_q[0].lo, col_q[1].lo), col_q[2].lo);
		mi_s3   <= med3(col_q[0].md, col_q[1].md, col_q[2].md);
		hi_s3   <= pmin(pmin(col_q[0].hi, col_q[1].hi), col_q[2].hi);
	end

	assign push                = emit_s3;
	assign push_word.pixel_out = int_s3 ? med3(lo_s3, mi_s3, hi_s3) : val_s3;
	assign push_word.frame_end = last_s3;
	assign pend                = 2'(emit_s2) + 2'(emit_s3);

endmodule

@@ sv/mf3_ofifo.sv @@
// mf3_ofifo: small output queue that drives the result channel
// depends on mf3_pkg and mf3_out_if
`timescale 1ns / 1ps

module mf3_ofifo import mf3_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  out_word_t                  wdata,
	output logic [$clog2(DEPTH+1)-1:0] cnt,
	mf3_out_if.source                  results
);

	localparam int AW = $clog2(DEPTH);

	out_word_t        mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic             pop;

	assign pop               = results.valid & results.ready;
	assign results.valid     = (cnt != '0);
	assign results.pixel_out = mem_q[rd_q].pixel_out;
	assign results.frame_end = mem_q[rd_q].frame_end;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt  <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt <= cnt + 1'b1;
				2'b01:   cnt <= cnt - 1'b1;
				default: cnt <= cnt;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && cnt == ($clog2(DEPTH+1))'(DEPTH)))
		else $error("output queue overflow");

endmodule

@@ sv/median_filter_3x3.sv @@
// median_filter_3x3: streaming 3x3 median over two row store RAMs
// depends on mf3_pkg, mf3_in_if, mf3_out_if, mf3_ram, mf3_cfg, mf3_median, mf3_ofifo
//
//  channel   dir  handshake      word
//  pixels    in   valid/ready    cmd, pixel_in
//  results   out  valid/ready    pixel_out, frame_end
//  apb       in   psel/penable   frame_width @0x0, frame_height @0x4
//
// one word per clock while ready is high; a result passes the s1, s2 and s3 registers and the
// output queue before it is valid on results
// the row stores are read at accept and the upper row is written back in the next cycle
// reset clears counters, window and queue; row store contents stay undefined until written
// ready falls only when the 8-entry output queue plus words in flight could overflow
`timescale 1ns / 1ps

module median_filter_3x3 import mf3_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	mf3_in_if.sink             pixels,
	mf3_out_if.source          results,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int CNTW = $clog2(OFIFO_DEPTH + 1);

	logic [CW-1:0]   wm1;
	logic [RW-1:0]   hm1;
	logic            clr;

	logic [CW-1:0]   in_col_q;
	logic [RW-1:0]   in_row_q;
	logic            in_done_q;
	logic [CW-1:0]   out_col_q;
	logic [RW-1:0]   out_row_q;

	logic            acc;
	logic            take;
	logic            drn;
	logic            emit;
	logic            last;
	logic            interior;

	stage_t          s1_q;
	pix_t            pix_s1;
	logic [CW-1:0]   ci_s1;

	pix_t            rd_upper;
	pix_t            rd_lower;
	logic            push;
	out_word_t       push_word;
	logic [1:0]      pend;
	logic [CNTW-1:0] fifo_cnt;
	logic [CNTW-1:0] credits;

	mf3_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.wm1     (wm1),
		.hm1     (hm1),
		.clr     (clr)
	);

	assign credits      = CNTW'(fifo_cnt) + CNTW'(s1_q.emit) + CNTW'(pend);
	assign pixels.ready = (credits < CNTW'(OFIFO_DEPTH));

	assign acc  = pixels.valid & pixels.ready;
	assign take = acc & (cmd_t'(pixels.cmd) == CMD_PIXEL) & !in_done_q;
	assign drn  = acc & (cmd_t'(pixels.cmd) == CMD_DRAIN) & in_done_q;

	// a pixel yields a result once the window trails the input by a row and a pixel
	assign emit = (take && in_row_q != '0 && !(in_row_q == RW'(1) && in_col_q == '0)) || drn;
	assign last = (out_row_q == hm1) && (out_col_q == wm1);
	assign interior = (out_row_q != '0) && (out_row_q != hm1)
		&& (out_col_q != '0) && (out_col_q != wm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_done_q <= 1'b0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (clr) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_done_q <= 1'b0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (take) begin
				if (in_col_q == wm1) begin
					in_col_q <= '0;
					if (in_row_q == hm1) begin
						in_row_q  <= '0;
						in_done_q <= 1'b1;
					end else begin
						in_row_q <= in_row_q + 1'b1;
					end
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (emit) begin
				if (last) begin
					out_col_q <= '0;
					out_row_q <= '0;
					in_done_q <= 1'b0;
				end else if (out_col_q == wm1) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
		end else begin
			s1_q.shift    <= take;
			s1_q.emit     <= emit;
			s1_q.interior <= interior;
			s1_q.last     <= last;
			s1_q.drain    <= drn;
			s1_q.j0       <= (out_row_q != hm1);
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= pixels.pixel_in;
		ci_s1  <= in_col_q;
	end

	// lower row: new pixel goes in at accept, the old value comes out read-first
	mf3_ram #(
		.WIDTH (8),
		.DEPTH (MAX_WIDTH)
	) u_row_lower (
		.clk   (clk),
		.we    (take),
		.waddr (in_col_q),
		.wdata (pixels.pixel_in),
		.re    (take | drn),
		.raddr (take ? in_col_q : out_col_q),
		.rdata (rd_lower)
	);

	// upper row: takes the old lower value in the cycle after the read
	mf3_ram #(
		.WIDTH (8),
		.DEPTH (MAX_WIDTH)
	) u_row_upper (
		.clk   (clk),
		.we    (s1_q.shift),
		.waddr (ci_s1),
		.wdata (rd_lower),
		.re    (take),
		.raddr (in_col_q),
		.rdata (rd_upper)
	);

	mf3_median u_median (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (clr),
		.s1        (s1_q),
		.pix_s1    (pix_s1),
		.rd_upper  (rd_upper),
		.rd_lower  (rd_lower),
		.push      (push),
		.push_word (push_word),
		.pend      (pend)
	);

	mf3_ofifo #(
		.DEPTH (OFIFO_DEPTH)
	) u_ofifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wdata   (push_word),
		.cnt     (fifo_cnt),
		.results (results)
	);

	a_upper_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_q.shift && take && ci_s1 == in_col_q))
		else $error("upper row store read and write hit the same column");

	a_done_at_origin: assert property (@(posedge clk) disable iff (!arst_n)
		in_done_q |-> (in_col_q == '0 && in_row_q == '0))
		else $error("input counters not at origin while draining");

	a_last_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last && !clr) |=> !in_done_q)
		else $error("frame end did not rearm input");

endmodule

@@ bench/tb_median_filter_3x3.sv @@
// tb_median_filter_3x3: self-checking bench for the streaming 3x3 median filter
// depends on mf3_pkg, mf3_in_if, mf3_out_if and the median_filter_3x3 rtl
// words are paced at random, results are predicted per accepted word and checked in order
`timescale 1ns / 1ps

module tb_median_filter_3x3 import mf3_pkg::*; ();

	localparam int unsigned MAX_DIM        = 2048;
	localparam int unsigned RANDOM_ITEMS   = 620;
	localparam int unsigned SETTLE_CYCLES  = 10;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		cmd_t cmd;
		pix_t pix;
	} in_word_t;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_SPARSE,
		SINK_PERIODIC
	} sink_mode_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	mf3_in_if  pixel_ch ();
	mf3_out_if result_ch ();

	median_filter_3x3 #(.MAX_WIDTH(MAX_DIM), .MAX_HEIGHT(MAX_DIM)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pixel_ch),
		.results (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// filter state as the block should hold it
	pix_t             upper_row [MAX_DIM];
	pix_t             lower_row [MAX_DIM];
	pix_t [2:0][2:0]  win;        // [column oldest..newest][row top..bottom]
	int unsigned      pix_taken;
	int unsigned      pix_given;
	logic [11:0]      width_reg  = 12'd640;
	logic [11:0]      height_reg = 12'd480;

	in_word_t    pending_words[$];
	out_word_t   expected_pixels[$];
	out_word_t   predicted_word;
	out_word_t   oldest;
	in_word_t    next_word;

	int unsigned words_queued;
	int unsigned words_accepted;
	int unsigned results_seen;
	int unsigned mismatches;
	int unsigned frame_words;
	int unsigned frames_done;
	int unsigned frames_cut;
	int unsigned reg_writes;
	int unsigned hold_requests;
	int unsigned holds_done;
	int unsigned hold_left;
	int unsigned quiet_cycles;
	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned mode_left;
	int unsigned period = 3;
	int unsigned tick;
	sink_mode_t  sink_mode = SINK_OPEN;

	function automatic int unsigned clamp_dim(input logic [11:0] raw);
		if (raw < 12'd3)
			return 3;
		if (raw > MAX_DIM)
			return MAX_DIM;
		return int'(raw);
	endfunction

	// median as the value whose rank window covers the fifth place
	function automatic pix_t window_median();
		pix_t vals [9];
		int   below;
		int   same;
		for (int i = 0; i < 9; i++)
			vals[i] = win[i / 3][i % 3];
		for (int i = 0; i < 9; i++) begin
			below = 0;
			same  = 0;
			for (int j = 0; j < 9; j++) begin
				if (vals[j] < vals[i])
					below++;
				else if (vals[j] == vals[i])
					same++;
			end
			if (below <= 4 && below + same >= 5)
				return vals[i];
		end
		return vals[4];
	endfunction

	function automatic bit filter_step(input cmd_t cmd, input pix_t pix, output out_word_t word);
		int unsigned w;
		int unsigned h;
		int unsigned total;
		int unsigned col;
		int unsigned k;
		pix_t        top;
		pix_t        mid;
		w     = clamp_dim(width_reg);
		h     = clamp_dim(height_reg);
		total = w * h;
		word  = '0;
		if (cmd == CMD_PIXEL) begin
			if (pix_taken >= total)
				return 0;
			col            = pix_taken % w;
			top            = upper_row[col];
			mid            = lower_row[col];
			upper_row[col] = mid;
			lower_row[col] = pix;
			win[0]         = win[1];
			win[1]         = win[2];
			win[2]         = {pix, mid, top};
			pix_taken++;
			if (pix_taken <= w + 1)
				return 0;
			k = pix_taken - w - 2;
			if (k / w >= 1 && k / w <= h - 2 && k % w >= 1 && k % w <= w - 2)
				word.pixel_out = window_median();
			else
				word.pixel_out = win[1][1];
		end else begin
			if (pix_taken < total)
				return 0;
			k = pix_given;
			if (k < total - w - 1 || k >= total)
				return 0;
			// the tail comes straight out of the row stores
			if (k == total - w - 1)
				word.pixel_out = upper_row[w - 1];
			else
				word.pixel_out = lower_row[k - (total - w)];
		end
		word.frame_end = (k == total - 1);
		pix_given      = k + 1;
		if (word.frame_end) begin
			pix_taken = 0;
			pix_given = 0;
		end
		return 1;
	endfunction

	function automatic void note_error(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endfunction

	function automatic pix_t next_pixel(input bit clustered);
		if (clustered && $urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 3))
				0: return 8'h00;
				1: return 8'hFF;
				2: return 8'h7F;
				default: return 8'h80;
			endcase
		end
		return pix_t'($urandom_range(0, 255));
	endfunction

	function automatic void push_word(input cmd_t cmd, input pix_t pix);
		pending_words.push_back('{cmd: cmd, pix: pix});
		words_queued++;
	endfunction

	function automatic logic [11:0] pick_dim();
		if ($urandom_range(0, 7) == 0)
			return 12'($urandom_range(0, 2));
		return 12'($urandom_range(3, 10));
	endfunction

	// one frame at the current setting, optionally cut short or salted with stray words
	task automatic gen_frame(input bit noisy, input int unsigned cut);
		int unsigned w;
		int unsigned total;
		int unsigned n_px;
		bit          clustered;
		w         = clamp_dim(width_reg);
		total     = w * clamp_dim(height_reg);
		n_px      = (cut != 0) ? cut : total;
		clustered = 1'($urandom_range(0, 1));
		for (int unsigned i = 0; i < n_px; i++) begin
			if (noisy && $urandom_range(0, 39) == 0)
				push_word(CMD_DRAIN, pix_t'($urandom));
			push_word(CMD_PIXEL, next_pixel(clustered));
		end
		frame_words += n_px;
		if (cut != 0) begin
			frames_cut++;
			return;
		end
		for (int unsigned i = 0; i <= w; i++) begin
			if (noisy && $urandom_range(0, 15) == 0)
				push_word(CMD_PIXEL, pix_t'($urandom));
			push_word(CMD_DRAIN, pix_t'($urandom));
		end
		if (noisy && $urandom_range(0, 2) == 0)
			push_word(CMD_DRAIN, pix_t'($urandom));
		frame_words += w + 1;
		frames_done++;
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [11:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * idx);
		pwdata  <= {20'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_WIDTH)
			width_reg = value;
		else
			height_reg = value;
		pix_taken = 0;
		pix_given = 0;
		win       = '0;
		reg_writes++;
	endtask

	// all words taken, all results in, then room for words that give no result
	task automatic wait_idle();
		do
			@(posedge clk);
		while (words_accepted != words_queued || expected_pixels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin : word_driver
		if (!arst_n) begin
			pixel_ch.valid <= 1'b0;
		end else if (!pixel_ch.valid || pixel_ch.ready) begin
			if (gap_left != 0) begin
				gap_left--;
				pixel_ch.valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				next_word = pending_words.pop_front();
				pixel_ch.valid    <= 1'b1;
				pixel_ch.cmd      <= next_word.cmd;
				pixel_ch.pixel_in <= next_word.pix;
				if (burst_left != 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 60);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				pixel_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : sink_pacing
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (holds_done != hold_requests) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				sink_mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(40, 300);
				period    = $urandom_range(2, 7);
			end else begin
				mode_left--;
			end
			tick++;
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				case (sink_mode)
					SINK_OPEN:   result_ch.ready <= 1'b1;
					SINK_COIN:   result_ch.ready <= $urandom_range(0, 1);
					SINK_SPARSE: result_ch.ready <= ($urandom_range(0, 4) == 0);
					default:     result_ch.ready <= (tick % period) != 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin : scoreboard
		if (arst_n) begin
			if (pixel_ch.valid && pixel_ch.ready) begin
				words_accepted++;
				if (filter_step(cmd_t'(pixel_ch.cmd), pixel_ch.pixel_in, predicted_word))
					expected_pixels.push_back(predicted_word);
			end
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (expected_pixels.size() == 0) begin
					note_error($sformatf("unexpected word pixel_out=%0d frame_end=%0b",
						result_ch.pixel_out, result_ch.frame_end));
				end else begin
					oldest = expected_pixels.pop_front();
					if (result_ch.pixel_out !== oldest.pixel_out
							|| result_ch.frame_end !== oldest.frame_end)
						note_error($sformatf(
							"result %0d: expected pixel_out=%0d frame_end=%0b, got %0d %0b",
							results_seen, oldest.pixel_out, oldest.frame_end,
							result_ch.pixel_out, result_ch.frame_end));
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (pixel_ch.valid && pixel_ch.ready)
				|| (result_ch.valid && result_ch.ready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, expected_pixels.size());
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [11:0] w_raw;
		logic [11:0] h_raw;
		int unsigned frames;
		int unsigned cut;
		int unsigned phase;
		int unsigned words_before_random;
		arst_n            = 1'b0;
		pixel_ch.valid    = 1'b0;
		pixel_ch.cmd      = 1'b0;
		pixel_ch.pixel_in = 8'h00;
		result_ch.ready   = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// below-minimum settings both act as a 3x3 frame
		write_register(REG_WIDTH, 12'd0);
		write_register(REG_HEIGHT, 12'd2);
		push_word(CMD_DRAIN, 8'h5A);
		for (int i = 0; i < 9; i++) begin
			if (i == 4)
				push_word(CMD_DRAIN, 8'hC3);
			push_word(CMD_PIXEL, (i % 2) ? 8'h00 : 8'hFF);
		end
		push_word(CMD_DRAIN, 8'h00);
		push_word(CMD_DRAIN, 8'hFF);
		push_word(CMD_PIXEL, 8'hA5);
		push_word(CMD_DRAIN, 8'h0F);
		push_word(CMD_DRAIN, 8'hF0);
		push_word(CMD_DRAIN, 8'h3C);
		frames_done++;
		wait_idle();
		// a partial frame, thrown away by the next register write
		for (int i = 0; i < 5; i++)
			push_word(CMD_PIXEL, pix_t'(8'hFF - 8'(i)));
		frames_cut++;
		wait_idle();

		// widest setting gives no result yet, then a tall cut frame under a long sink stall
		case ($urandom_range(0, 2))
			0: write_register(REG_WIDTH, 12'd2048);
			1: write_register(REG_WIDTH, 12'd2049);
			default: write_register(REG_WIDTH, 12'd4095);
		endcase
		write_register(REG_HEIGHT, 12'd1);
		gen_frame(1'b0, 40);
		wait_idle();
		write_register(REG_WIDTH, 12'd3);
		write_register(REG_HEIGHT, $urandom_range(0, 1) ? 12'd2048 : 12'd4095);
		gen_frame(1'b0, 150);
		hold_requests++;
		wait_idle();

		words_before_random = frame_words;
		phase = 0;
		while (frame_words - words_before_random < RANDOM_ITEMS) begin
			w_raw = pick_dim();
			h_raw = pick_dim();
			case ($urandom_range(0, 3))
				0: write_register(REG_WIDTH, w_raw);
				1: write_register(REG_HEIGHT, h_raw);
				default: begin
					write_register(REG_WIDTH, w_raw);
					write_register(REG_HEIGHT, h_raw);
				end
			endcase
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				cut = 0;
				if (f == frames - 1 && $urandom_range(0, 5) == 0)
					cut = $urandom_range(1,
						clamp_dim(width_reg) * clamp_dim(height_reg) - 1);
				gen_frame($urandom_range(0, 1), cut);
			end
			if (phase == 2)
				hold_requests++;
			phase++;
			wait_idle();
		end

		$display("covered %0d full frames and %0d cut short, %0d words in, %0d results checked",
			frames_done, frames_cut, words_accepted, results_seen);
		$display("%0d register writes, sizes 3 to 2048 incl. clamped values, %0d mismatches",
			reg_writes, mismatches);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/mf3_pkg.sv
sv/mf3_in_if.sv
sv/mf3_out_if.sv
sv/mf3_ram.sv
sv/mf3_cfg.sv
sv/mf3_median.sv
sv/mf3_ofifo.sv
sv/median_filter_3x3.sv
bench/tb_median_filter_3x3.sv
